/* sv/cbad_pkg.sv */
// ----------------------------------------------------------------------------
// cbad_pkg
// Shared types and constants for the bus address decoder: field widths,
// region codes, fault codes and the physical region map.
// ----------------------------------------------------------------------------
package cbad_pkg;

	localparam int unsigned VA_W   = 32;
	localparam int unsigned SIZE_W = 2;
	localparam int unsigned OFF_W  = 30;

	typedef logic [VA_W-1:0]   addr_t;
	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [OFF_W-1:0]  off_t;

	// target region codes
	typedef enum logic [3:0] {
		TGT_RAM     = 4'd0,
		TGT_EXP1    = 4'd1,
		TGT_SCRATCH = 4'd2,
		TGT_IO      = 4'd3,
		TGT_GPUREAD = 4'd4,
		TGT_GP0     = 4'd5,
		TGT_GPUSTAT = 4'd6,
		TGT_GP1     = 4'd7,
		TGT_EXP2    = 4'd8,
		TGT_EXP3    = 4'd9,
		TGT_BIOS    = 4'd10,
		TGT_KSEG2   = 4'd11,
		TGT_NONE    = 4'd12
	} tgt_t;

	// alignment fault codes
	typedef enum logic [1:0] {
		FLT_NONE  = 2'd0,
		FLT_LOAD  = 2'd1,
		FLT_STORE = 2'd2
	} fault_t;

	// access size codes
	localparam size_t SZ_BYTE = 2'd0;
	localparam size_t SZ_HALF = 2'd1;

	// segment codes in virt_address[31:29]
	localparam logic [2:0] SEG_KSEG0 = 3'd4;
	localparam logic [2:0] SEG_KSEG1 = 3'd5;

	localparam addr_t KSEG0_MASK = 32'h7FFF_FFFF;
	localparam addr_t KSEG1_MASK = 32'h1FFF_FFFF;
	localparam addr_t ISO_MASK   = 32'h0000_03FF;

	// physical region map
	localparam addr_t RAM_END      = 32'h0020_0000;
	localparam addr_t EXP1_BASE    = 32'h1F00_0000;
	localparam addr_t SCRATCH_BASE = 32'h1F80_0000;
	localparam addr_t IO_BASE      = 32'h1F80_1000;
	localparam addr_t GPU0_BASE    = 32'h1F80_1810;
	localparam addr_t GPU1_BASE    = 32'h1F80_1814;
	localparam addr_t GPU1_END     = 32'h1F80_1818;
	localparam addr_t EXP2_BASE    = 32'h1F80_2000;
	localparam addr_t EXP3_BASE    = 32'h1FA0_0000;
	localparam addr_t BIOS_BASE    = 32'h1FC0_0000;
	localparam addr_t BIOS_END     = 32'h1FC8_0000;
	localparam addr_t KSEG2_BASE   = 32'hC000_0000;

endpackage

/* sv/cbad_if.sv */
// ----------------------------------------------------------------------------
// cbad_if
// Valid/ready channels of the bus address decoder: bus access requests in,
// decode results out.
// ----------------------------------------------------------------------------
interface cbad_req_if;
	import cbad_pkg::*;

	logic  valid;
	logic  ready;
	addr_t virt_address;
	size_t access_size;
	logic  action;
	logic  cache_isolated;

	modport source (output valid, virt_address, access_size, action, cache_isolated,
		input ready);
	modport sink (input valid, virt_address, access_size, action, cache_isolated,
		output ready);
endinterface

interface cbad_rsp_if;
	import cbad_pkg::*;

	logic       valid;
	logic       ready;
	logic [3:0] target_region;
	off_t       region_offset;
	logic [1:0] align_fault;
	logic       unmapped;

	modport source (output valid, target_region, region_offset, align_fault, unmapped,
		input ready);
	modport sink (input valid, target_region, region_offset, align_fault, unmapped,
		output ready);
endinterface

/* sv/cpu_bus_address_decoder.sv */
// ----------------------------------------------------------------------------
// cpu_bus_address_decoder
// Decodes one processor bus access into target region, offset, alignment
// fault and unmapped flag.
// ----------------------------------------------------------------------------
// Takes one access per cycle while the result side does not stall: the
// access is captured in an input register, the segment mask, region compare
// and offset subtract run in one pass, and the result sits in an output
// register until taken. A stall on the result side holds both stages; with
// the output free the request side stays ready every cycle. KSEG0 clears
// address bit 31, KSEG1 keeps the low 29 bits, KUSEG and KSEG2 pass through.
// With cache isolate set, main RAM accesses go to the scratchpad at offset
// modulo 1 KiB. GPU port accesses report offset zero.
// ----------------------------------------------------------------------------
module cpu_bus_address_decoder (
	input logic      clk,
	input logic      arst_n,
	cbad_req_if.sink req,
	cbad_rsp_if.source rsp
);
	import cbad_pkg::*;

	logic   v_s1;
	addr_t  va_s1;
	size_t  size_s1;
	logic   store_s1;
	logic   iso_s1;

	logic   v_s2;
	tgt_t   tgt_s2;
	off_t   off_s2;
	fault_t fault_s2;

	logic   adv1;
	logic   adv2;

	addr_t  p;
	addr_t  diff;
	logic   misaligned;
	tgt_t   tgt_d;
	off_t   off_d;
	fault_t fault_d;

	assign adv2      = !v_s2 || rsp.ready;
	assign adv1      = !v_s1 || adv2;
	assign req.ready = adv1;

	// segment mask
	always_comb begin
		case (va_s1[31:29])
			SEG_KSEG0: p = va_s1 & KSEG0_MASK;
			SEG_KSEG1: p = va_s1 & KSEG1_MASK;
			default:   p = va_s1;
		endcase
	end

	always_comb begin
		case (size_s1)
			SZ_BYTE: misaligned = 1'b0;
			SZ_HALF: misaligned = va_s1[0];
			default: misaligned = |va_s1[1:0];
		endcase
		if (!misaligned)
			fault_d = FLT_NONE;
		else if (store_s1)
			fault_d = FLT_STORE;
		else
			fault_d = FLT_LOAD;
	end

	// region match; the offset is the base subtract, or for RAM the address itself (masked when isolated)
	always_comb begin
		tgt_d = TGT_NONE;
		diff  = '0;
		if (p < RAM_END) begin
			tgt_d = iso_s1 ? TGT_SCRATCH : TGT_RAM;
			diff  = iso_s1 ? (p & ISO_MASK) : p;
		end else if (p >= EXP1_BASE && p < SCRATCH_BASE) begin
			tgt_d = TGT_EXP1;
			diff  = p - EXP1_BASE;
		end else if (p >= SCRATCH_BASE && p < IO_BASE) begin
			tgt_d = TGT_SCRATCH;
			diff  = p - SCRATCH_BASE;
		end else if (p >= IO_BASE && p < EXP2_BASE) begin
			if (p >= GPU0_BASE && p < GPU1_BASE) begin
				tgt_d = store_s1 ? TGT_GP0 : TGT_GPUREAD;
			end else if (p >= GPU1_BASE && p < GPU1_END) begin
				tgt_d = store_s1 ? TGT_GP1 : TGT_GPUSTAT;
			end else begin
				tgt_d = TGT_IO;
				diff  = p - IO_BASE;
			end
		end else if (p >= EXP2_BASE && p < EXP3_BASE) begin
			tgt_d = TGT_EXP2;
			diff  = p - EXP2_BASE;
		end else if (p >= EXP3_BASE && p < BIOS_BASE) begin
			tgt_d = TGT_EXP3;
			diff  = p - EXP3_BASE;
		end else if (p >= BIOS_BASE && p < BIOS_END) begin
			tgt_d = TGT_BIOS;
			diff  = p - BIOS_BASE;
		end else if (p >= KSEG2_BASE) begin
			tgt_d = TGT_KSEG2;
			diff  = p - KSEG2_BASE;
		end
		off_d = diff[OFF_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1)
				v_s1 <= req.valid;
			if (adv2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && req.valid) begin
			va_s1    <= req.virt_address;
			size_s1  <= req.access_size;
			store_s1 <= req.action;
			iso_s1   <= req.cache_isolated;
		end
		if (adv2 && v_s1) begin
			tgt_s2   <= tgt_d;
			off_s2   <= off_d;
			fault_s2 <= fault_d;
		end
	end

	assign rsp.valid         = v_s2;
	assign rsp.target_region = tgt_s2;
	assign rsp.region_offset = off_s2;
	assign rsp.align_fault   = fault_s2;
	assign rsp.unmapped      = (tgt_s2 == TGT_NONE);

endmodule

/* sv/cbad_checker.sv */
// ----------------------------------------------------------------------------
// cbad_checker
// Port-level checks for the bus address decoder, bound to the top level.
// ----------------------------------------------------------------------------
module cbad_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [3:0]           target_region,
	input cbad_pkg::off_t       region_offset,
	input logic [1:0]           align_fault,
	input logic                 unmapped
);
	import cbad_pkg::*;

	// a result waiting on the sink keeps its contents
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(target_region)
			&& $stable(region_offset) && $stable(align_fault))
		else $error("result changed while stalled");

	a_unmapped: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> unmapped == (target_region == TGT_NONE))
		else $error("unmapped flag disagrees with region");

	a_gpu_off: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (target_region == TGT_GPUREAD || target_region == TGT_GP0
			|| target_region == TGT_GPUSTAT || target_region == TGT_GP1
			|| target_region == TGT_NONE) |-> region_offset == '0)
		else $error("nonzero offset on GPU port or unmapped access");

	a_ram_off: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && target_region == TGT_RAM |-> region_offset[OFF_W-1:21] == '0)
		else $error("RAM offset beyond 2 MiB");

endmodule

bind cpu_bus_address_decoder cbad_checker u_cbad_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.target_region (rsp.target_region),
	.region_offset (rsp.region_offset),
	.align_fault   (rsp.align_fault),
	.unmapped      (rsp.unmapped)
);
